FILE: rtl/core/websocket_frame_deframer_unmask_unit_defines.svh
// assertion macros shared by the checker file
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define WFDU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfdu: same-cycle check failed");

// next-cycle implication, off during reset
`define WFDU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfdu: next-cycle check failed");

`endif

FILE: rtl/core/wfdu_pkg.sv
`default_nettype none
package wfdu_pkg;

  // parser phase codes
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // result kind codes
  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_DONE = 3'd1;
  localparam logic [2:0] KIND_PAY  = 3'd2;
  localparam logic [2:0] KIND_ERR  = 3'd3;
  localparam logic [2:0] KIND_DISC = 3'd4;

  // 7-bit length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // masked header sizes for each length form
  localparam logic [3:0] HDR_SHORT = 4'd6;
  localparam logic [3:0] HDR_MID   = 4'd8;
  localparam logic [3:0] HDR_LONG  = 4'd14;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  phase_count;
    logic [3:0]  frame_opcode;
    logic        frame_fin;
    logic [63:0] frame_length;
    logic [63:0] bytes_left;
    logic [31:0] mask_key;
    logic [1:0]  key_index;
    logic        error_frame;
    logic [3:0]  hdr_count;
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic [63:0] payload_length;
    logic [3:0]  header_bytes;
    logic        last;
  } result_t;

  localparam state_t STATE_RESET = '0;

endpackage
`default_nettype wire

FILE: rtl/core/websocket_frame_deframer_unmask_unit.sv
// pipeline: input register, then result register; the parse and xor step
// between them is combinational; one byte per cycle when not stalled
// reset: synchronous active-high rst empties both stages and returns the
// parser to the first header byte with all frame fields cleared
`default_nettype none
module websocket_frame_deframer_unmask_unit (
  input  wire  logic        clk,
  input  wire  logic        rst,
  // input byte stream
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [7:0]  in_byte,
  // result stream
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [2:0]        kind,
  output logic [7:0]        data,
  output logic [3:0]        opcode,
  output logic              fin,
  output logic [63:0]       payload_length,
  output logic [3:0]        header_bytes,
  output logic              last
);
  import wfdu_pkg::*;

  // stage 1: input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parser state and result register
  state_t  st;
  state_t  st_next;
  result_t res;
  result_t res_q;

  logic advance;

  // result stage frees up when empty or when its word is taken
  assign advance  = ~(out_valid & out_stall);
  // input stage holds only when it is full and cannot hand over
  assign in_stall = s1_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // byte register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  // one parse step per byte: phase walk, length shift, key shift, xor
  wfdu_parse u_parse (
    .st      (st),
    .in_byte (s1_byte),
    .st_next (st_next),
    .res     (res)
  );

  // frame state moves only when the byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      res_q <= res;
    end
  end

  assign kind           = res_q.kind;
  assign data           = res_q.data;
  assign opcode         = res_q.opcode;
  assign fin            = res_q.fin;
  assign payload_length = res_q.payload_length;
  assign header_bytes   = res_q.header_bytes;
  assign last           = res_q.last;
endmodule
`default_nettype wire

FILE: rtl/core/wfdu_parse.sv
`default_nettype none
module wfdu_parse (
  input  wire  wfdu_pkg::state_t  st,
  input  wire  logic [7:0]        in_byte,
  output wfdu_pkg::state_t        st_next,
  output wfdu_pkg::result_t       res
);
  import wfdu_pkg::*;

  logic [6:0]  code;
  logic [7:0]  key_byte;
  logic [63:0] left_dec;
  logic        len_done;

  assign code     = in_byte[6:0];
  assign key_byte = st.mask_key[{~st.key_index, 3'b000} +: 8];
  assign left_dec = st.bytes_left - 64'd1;

  always_comb begin
    st_next  = st;
    res      = '0;
    res.kind = KIND_HDR;
    len_done = 1'b0;

    unique case (st.phase)
      PH_SECOND: begin
        st_next.hdr_count   = 4'd2;
        st_next.error_frame = ~in_byte[7];
        res.kind            = in_byte[7] ? KIND_HDR : KIND_ERR;
        if (code == LEN_EXT16) begin
          st_next.phase_count  = EXT16_BYTES;
          st_next.frame_length = '0;
          st_next.phase        = PH_EXTLEN;
        end else if (code == LEN_EXT64) begin
          st_next.phase_count  = EXT64_BYTES;
          st_next.frame_length = '0;
          st_next.phase        = PH_EXTLEN;
        end else begin
          st_next.frame_length = {57'd0, code};
          len_done             = 1'b1;
        end
      end
      PH_EXTLEN: begin
        st_next.frame_length = {st.frame_length[55:0], in_byte};
        st_next.hdr_count    = st.hdr_count + 4'd1;
        st_next.phase_count  = st.phase_count - 4'd1;
        res.kind             = st.error_frame ? KIND_DISC : KIND_HDR;
        len_done             = (st_next.phase_count == 4'd0);
      end
      PH_KEY: begin
        st_next.mask_key    = {st.mask_key[23:0], in_byte};
        st_next.hdr_count   = st.hdr_count + 4'd1;
        st_next.phase_count = st.phase_count + 4'd1;
        if (st_next.phase_count >= KEY_BYTES) begin
          res.kind           = KIND_DONE;
          res.header_bytes   = st_next.hdr_count;
          st_next.key_index  = 2'd0;
          st_next.bytes_left = st.frame_length;
          if (st.frame_length == 64'd0) begin
            res.last      = 1'b1;
            st_next.phase = PH_FIRST;
          end else begin
            st_next.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (st.error_frame) begin
          res.kind = KIND_DISC;
        end else begin
          res.kind = KIND_PAY;
          res.data = in_byte ^ key_byte;
        end
        st_next.key_index  = st.key_index + 2'd1;
        st_next.bytes_left = left_dec;
        if (left_dec == 64'd0) begin
          res.last      = 1'b1;
          st_next.phase = PH_FIRST;
        end
      end
      default: begin
        // first header byte, also taken for unused phase codes
        st_next.frame_opcode = in_byte[3:0];
        st_next.frame_fin    = in_byte[7];
        st_next.frame_length = '0;
        st_next.bytes_left   = '0;
        st_next.error_frame  = 1'b0;
        st_next.mask_key     = '0;
        st_next.key_index    = 2'd0;
        st_next.phase_count  = 4'd0;
        st_next.hdr_count    = 4'd1;
        st_next.phase        = PH_SECOND;
      end
    endcase

    // length known: go to key, or skip an error frame's payload, ending at once if empty
    if (len_done) begin
      st_next.bytes_left = st_next.frame_length;
      if (st_next.error_frame) begin
        if (st_next.frame_length == 64'd0) begin
          res.last      = 1'b1;
          st_next.phase = PH_FIRST;
        end else begin
          st_next.phase = PH_PAYLOAD;
        end
      end else begin
        st_next.phase       = PH_KEY;
        st_next.phase_count = 4'd0;
      end
    end

    res.opcode         = st_next.frame_opcode;
    res.fin            = st_next.frame_fin;
    res.payload_length = st_next.frame_length;
  end
endmodule
`default_nettype wire

FILE: rtl/core/wfdu_checker.sv
`default_nettype none
`include "websocket_frame_deframer_unmask_unit_defines.svh"
module wfdu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  kind,
  input wire logic [7:0]  data,
  input wire logic [3:0]  opcode,
  input wire logic        fin,
  input wire logic [63:0] payload_length,
  input wire logic [3:0]  header_bytes,
  input wire logic        last
);
  import wfdu_pkg::*;

  logic        hdr_legal;
  logic [84:0] out_word;

  assign hdr_legal = (header_bytes == HDR_SHORT) || (header_bytes == HDR_MID) ||
                     (header_bytes == HDR_LONG);
  assign out_word  = {kind, data, opcode, fin, payload_length, header_bytes, last};

  // data only carries unmasked payload
  `WFDU_ASSERT_NOW(a_data_only_payload, clk, rst, out_valid && kind != KIND_PAY, data == 8'd0)

  // header size is one of the legal sizes on header completion
  `WFDU_ASSERT_NOW(a_hdr_size_legal, clk, rst, out_valid && kind == KIND_DONE, hdr_legal)

  // header size is zero on every other word
  `WFDU_ASSERT_NOW(a_hdr_size_zero, clk, rst, out_valid && kind != KIND_DONE, header_bytes == 4'd0)

  // a stalled result word holds
  `WFDU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // a stalled input word holds
  `WFDU_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_byte))

endmodule

bind websocket_frame_deframer_unmask_unit wfdu_checker u_wfdu_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wfdu_pkg::*;

  // how the payload length is carried in the frame header
  typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [3:0]  opcode;
  logic        fin;
  logic [63:0] payload_length;
  logic [3:0]  header_bytes;
  logic        last;

  // stream bytes still to send, and result words still to arrive
  logic [7:0]  frame_bytes[$];
  result_t     expected_words[$];
  int unsigned mismatches = 0;

  // sender and receiver idling
  int unsigned send_wait = 0;
  int unsigned stall_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  // deframer state as the scoreboard tracks it
  logic [2:0]  st_phase = PH_FIRST;
  logic [3:0]  st_count = '0;
  logic [3:0]  st_opcode = '0;
  logic        st_fin = 1'b0;
  logic [63:0] st_len = '0;
  logic [63:0] st_left = '0;
  logic [31:0] st_key = '0;
  logic [1:0]  st_kidx = '0;
  logic        st_err = 1'b0;
  logic [3:0]  st_hdr = '0;

  websocket_frame_deframer_unmask_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data           (data),
    .opcode         (opcode),
    .fin            (fin),
    .payload_length (payload_length),
    .header_bytes   (header_bytes),
    .last           (last)
  );

  always #10 clk = ~clk;

  // length is known: masked frames go on to the key, error frames skip
  // their payload, and an empty error frame ends right here
  function automatic logic close_length();
    logic ends;
    ends = 1'b0;
    st_left = st_len;
    if (st_err) begin
      if (st_len == '0) begin
        ends = 1'b1;
        st_phase = PH_FIRST;
      end else begin
        st_phase = PH_PAYLOAD;
      end
    end else begin
      st_phase = PH_KEY;
      st_count = '0;
    end
    return ends;
  endfunction

  // advance the tracked parser by one stream byte, return its result word
  function automatic result_t predict_word(logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_HDR;
    case (st_phase)
      PH_SECOND: begin
        st_hdr = 4'd2;
        st_err = ~b[7];
        r.kind = st_err ? KIND_ERR : KIND_HDR;
        if (b[6:0] == LEN_EXT16) begin
          st_count = EXT16_BYTES;
          st_len = '0;
          st_phase = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          st_count = EXT64_BYTES;
          st_len = '0;
          st_phase = PH_EXTLEN;
        end else begin
          st_len = {57'd0, b[6:0]};
          r.last = close_length();
        end
      end
      PH_EXTLEN: begin
        // big-endian, most significant byte first
        st_len = {st_len[55:0], b};
        st_hdr = st_hdr + 4'd1;
        st_count = st_count - 4'd1;
        r.kind = st_err ? KIND_DISC : KIND_HDR;
        if (st_count == '0) r.last = close_length();
      end
      PH_KEY: begin
        st_key = {st_key[23:0], b};
        st_hdr = st_hdr + 4'd1;
        st_count = st_count + 4'd1;
        if (st_count >= KEY_BYTES) begin
          r.kind = KIND_DONE;
          r.header_bytes = st_hdr;
          st_kidx = '0;
          st_left = st_len;
          if (st_len == '0) begin
            r.last = 1'b1;
            st_phase = PH_FIRST;
          end else begin
            st_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (st_err) begin
          r.kind = KIND_DISC;
        end else begin
          // key bytes rotate starting with the first one received
          r.kind = KIND_PAY;
          r.data = b ^ st_key[31 - 8 * st_kidx -: 8];
        end
        st_kidx = st_kidx + 2'd1;
        st_left = st_left - 64'd1;
        if (st_left == '0) begin
          r.last = 1'b1;
          st_phase = PH_FIRST;
        end
      end
      default: begin
        // first header byte, also any phase code that is not in use
        st_opcode = b[3:0];
        st_fin = b[7];
        st_len = '0;
        st_left = '0;
        st_err = 1'b0;
        st_key = '0;
        st_kidx = '0;
        st_count = '0;
        st_hdr = 4'd1;
        st_phase = PH_SECOND;
      end
    endcase
    r.opcode = st_opcode;
    r.fin = st_fin;
    r.payload_length = st_len;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // queue one frame; body may be shorter than len to leave a frame open
  task automatic add_frame(logic [7:0] head, bit masked, len_form_t form,
                           logic [63:0] len, int unsigned body);
    frame_bytes.push_back(head);
    case (form)
      FORM_EXT16: begin
        frame_bytes.push_back({masked, LEN_EXT16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      FORM_EXT64: begin
        frame_bytes.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8 * i +: 8]);
      end
      default: begin
        frame_bytes.push_back({masked, len[6:0]});
      end
    endcase
    if (masked) repeat (4) frame_bytes.push_back(8'($urandom));
    repeat (body) frame_bytes.push_back(8'($urandom));
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: a word is taken when valid is high and stall is low
  always @(posedge clk) begin : drive_bytes
    if (!rst) begin
      if (in_valid && !in_stall) expected_words.push_back(predict_word(in_byte));
      if ($urandom_range(0, 299) == 0) send_calm <= ~send_calm;
      // payload only moves once the current word is gone
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (frame_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte <= frame_bytes.pop_front();
          send_wait <= pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken result word, and stall the output at random
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d", kind);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind));
        check_field("data", 64'(want.data), 64'(data));
        check_field("opcode", 64'(want.opcode), 64'(opcode));
        check_field("fin", 64'(want.fin), 64'(fin));
        check_field("payload_length", want.payload_length, payload_length);
        check_field("header_bytes", 64'(want.header_bytes), 64'(header_bytes));
        check_field("last", 64'(want.last), 64'(last));
      end
    end
    if ($urandom_range(0, 299) == 0) recv_calm <= ~recv_calm;
    if (stall_wait != 0) begin
      out_stall <= 1'b1;
      stall_wait <= stall_wait - 1;
    end else begin
      out_stall <= 1'b0;
      stall_wait <= pick_gap(recv_calm);
    end
  end

  initial begin
    len_form_t   form;
    int unsigned size;
    int unsigned pick;
    bit          masked;

    // directed: empty masked control frame, header done carries last
    add_frame(8'h8A, 1'b1, FORM_SHORT, 64'd0, 0);
    // empty unmasked frame, error word carries last
    add_frame(8'h00, 1'b0, FORM_SHORT, 64'd0, 0);
    // empty unmasked frame with 16-bit length, last on the final length byte
    add_frame(8'h7F, 1'b0, FORM_EXT16, 64'd0, 0);
    // masked frame with 16-bit length, top four bits of byte one set
    add_frame(8'hF1, 1'b1, FORM_EXT16, 64'd2, 2);
    // unmasked frame with payload that gets discarded
    add_frame(8'h82, 1'b0, FORM_SHORT, 64'd2, 2);

    // random well-formed frames, random header bits, key and payload
    while (frame_bytes.size() < 1500) begin
      pick = $urandom_range(0, 99);
      masked = ($urandom_range(0, 99) < 85);
      if (pick < 70) begin
        form = FORM_SHORT;
        size = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end else if (pick < 88) begin
        form = FORM_EXT16;
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
      end else begin
        form = FORM_EXT64;
        size = $urandom_range(0, 20);
      end
      add_frame(8'($urandom), masked, form, 64'(size), size);
    end
    // full-scale 64-bit length with the top bit set, left open at the end
    add_frame(8'h81, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 6);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge
    do @(negedge clk); while (frame_bytes.size() != 0 || in_valid);
    while (expected_words.size() != 0) @(negedge clk);
    // catch stray words still in the pipe
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wfdu_pkg.sv
rtl/core/wfdu_parse.sv
rtl/core/websocket_frame_deframer_unmask_unit.sv
rtl/core/wfdu_checker.sv
dv/testbench.sv
